// ===== src/pds_pkg.sv =====
// pll divider search package
// shared constants, config register map and config struct
// no dependencies
package pds_pkg;

  localparam int REF_W  = 27;
  localparam int ML_W   = 7;
  localparam int NL_W   = 9;
  localparam int PL_W   = 3;
  localparam int TGT_W  = 31;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int M_BITS_DEF = 6;
  localparam int N_BITS_DEF = 8;
  localparam int P_BITS_DEF = 2;

  localparam logic [REF_W-1:0] REF_RST = REF_W'(14318180);
  localparam logic [ML_W-1:0]  ML_RST  = ML_W'(64);
  localparam logic [NL_W-1:0]  NL_RST  = NL_W'(256);
  localparam logic [PL_W-1:0]  PL_RST  = PL_W'(4);

  localparam logic [1:0] REG_REF = 2'd0;
  localparam logic [1:0] REG_ML  = 2'd1;
  localparam logic [1:0] REG_NL  = 2'd2;
  localparam logic [1:0] REG_PL  = 2'd3;

  typedef struct packed {
    logic [REF_W-1:0] ref_freq;
    logic [ML_W-1:0]  m_limit;
    logic [NL_W-1:0]  n_limit;
    logic [PL_W-1:0]  p_limit;
  } cfg_t;

endpackage

// ===== src/pds_regs.sv =====
// apb config registers of the pll divider search
// depends on pds_pkg
module pds_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pds_pkg::ADDR_W-1:0] paddr,
  input  logic [pds_pkg::DATA_W-1:0] pwdata,
  output logic [pds_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output pds_pkg::cfg_t             cfg
);
  import pds_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_freq <= REF_RST;
      cfg_r.m_limit  <= ML_RST;
      cfg_r.n_limit  <= NL_RST;
      cfg_r.p_limit  <= PL_RST;
    end else if (wr_en) begin
      case (idx)
        REG_REF: cfg_r.ref_freq <= pwdata[REF_W-1:0];
        REG_ML:  cfg_r.m_limit  <= pwdata[ML_W-1:0];
        REG_NL:  cfg_r.n_limit  <= pwdata[NL_W-1:0];
        REG_PL:  cfg_r.p_limit  <= pwdata[PL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REF: prdata = DATA_W'(cfg_r.ref_freq);
      REG_ML:  prdata = DATA_W'(cfg_r.m_limit);
      REG_NL:  prdata = DATA_W'(cfg_r.n_limit);
      REG_PL:  prdata = DATA_W'(cfg_r.p_limit);
      default: prdata = '0;
    endcase
  end

endmodule

// ===== src/pds_div.sv =====
// shared restoring divider, one quotient bit per cycle
// no dependencies
module pds_div #(
  parameter int PW = 36,
  parameter int DV = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [DV-1:0] divisor,
  output logic          done,
  output logic [PW-1:0] quot
);
  localparam int CW = $clog2(PW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] q_r;
  logic [DV-1:0] rem_r;
  logic [DV-1:0] dvs_r;
  logic [DV:0]   trial;
  logic          ge;
  logic [DV-1:0] rem_nxt;

  assign trial   = {rem_r, q_r[PW-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? DV'(trial - {1'b0, dvs_r}) : trial[DV-1:0];
  assign done    = done_r;
  assign quot    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(PW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[PW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== src/pds_ctrl.sv =====
// search sequencer: m/n/p loop counters, multiply, divider control, best tracking
// depends on pds_pkg; drives the shared pds_div
module pds_ctrl #(
  parameter int M_BITS = pds_pkg::M_BITS_DEF,
  parameter int N_BITS = pds_pkg::N_BITS_DEF,
  parameter int P_BITS = pds_pkg::P_BITS_DEF,
  parameter int PW     = pds_pkg::REF_W + N_BITS + 1,
  parameter int DV     = M_BITS + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pds_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [pds_pkg::TGT_W-1:0] in_target_freq,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [M_BITS-1:0]        out_best_m,
  output logic [N_BITS-1:0]        out_best_n,
  output logic [P_BITS-1:0]        out_best_p,
  output logic [pds_pkg::TGT_W-1:0] out_best_error,
  output logic                     out_found,
  output logic                     div_start,
  output logic [PW-1:0]            div_dividend,
  output logic [DV-1:0]            div_divisor,
  input  logic                     div_done,
  input  logic [PW-1:0]            div_quot
);
  import pds_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PSCAN = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam int MCAP = 1 << M_BITS;
  localparam int NCAP = 1 << N_BITS;
  localparam int PCAP = 1 << P_BITS;
  localparam int EW   = ((PW > TGT_W) ? PW : TGT_W) + 1;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [REF_W-1:0]   ref_r;
  logic [TGT_W-1:0]   tgt_r;
  logic [M_BITS:0]    mlim_r;
  logic [N_BITS:0]    nlim_r;
  logic [P_BITS:0]    plim_r;
  logic [M_BITS:0]    mlim;
  logic [N_BITS:0]    nlim;
  logic [P_BITS:0]    plim;
  logic [M_BITS-1:0]  m_r;
  logic [N_BITS-1:0]  n_r;
  logic [P_BITS-1:0]  p_r;
  logic [PW-1:0]      prod_r;
  logic [PW-1:0]      f_r;
  logic [TGT_W-1:0]   best_r;
  logic [M_BITS-1:0]  bm_r;
  logic [N_BITS-1:0]  bn_r;
  logic [P_BITS-1:0]  bp_r;
  logic               found_r;
  logic               out_valid_r;
  logic [M_BITS-1:0]  om_r;
  logic [N_BITS-1:0]  on_r;
  logic [P_BITS-1:0]  op_r;
  logic [TGT_W-1:0]   oerr_r;
  logic               ofound_r;
  logic [N_BITS:0]    nop;
  logic [PW-1:0]      fo;
  logic [EW-1:0]      diff;
  logic [EW-1:0]      mag;
  logic               better;
  logic               p_last;
  logic               n_last;
  logic               m_last;
  logic               empty;
  logic               accept;
  logic               out_free;

  assign mlim = (int'(cfg.m_limit) > MCAP) ? (M_BITS+1)'(MCAP) : (M_BITS+1)'(cfg.m_limit);
  assign nlim = (int'(cfg.n_limit) > NCAP) ? (N_BITS+1)'(NCAP) : (N_BITS+1)'(cfg.n_limit);
  assign plim = (int'(cfg.p_limit) > PCAP) ? (P_BITS+1)'(PCAP) : (P_BITS+1)'(cfg.p_limit);
  assign empty = (mlim < (M_BITS+1)'(2)) || (nlim < (N_BITS+1)'(2)) ||
                 (plim == '0);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign nop          = (N_BITS+1)'(n_r) + (N_BITS+1)'(2);
  assign div_start    = (state_r == S_START);
  assign div_dividend = prod_r;
  assign div_divisor  = DV'(m_r) + DV'(2);

  assign fo     = f_r >> p_r;
  assign diff   = EW'(tgt_r) - EW'(fo);
  assign mag    = diff[EW-1] ? EW'(-diff) : diff;
  assign better = mag < EW'(best_r);

  assign p_last = ((P_BITS+1)'(p_r) + 1'b1) == plim_r;
  assign n_last = ((N_BITS+1)'(n_r) + 1'b1) == nlim_r;
  assign m_last = ((M_BITS+1)'(m_r) + 1'b1) == mlim_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = empty ? S_FIN : S_MUL;
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_PSCAN;
      S_PSCAN: begin
        if (p_last) state_nxt = (n_last && m_last) ? S_FIN : S_MUL;
      end
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ref_r   <= cfg.ref_freq;
          tgt_r   <= in_target_freq;
          mlim_r  <= mlim;
          nlim_r  <= nlim;
          plim_r  <= plim;
          m_r     <= M_BITS'(1);
          n_r     <= N_BITS'(1);
          best_r  <= in_target_freq;
          bm_r    <= '0;
          bn_r    <= '0;
          bp_r    <= '0;
          found_r <= 1'b0;
        end
      end
      S_MUL: prod_r <= PW'(ref_r) * PW'(nop);
      S_DIV: begin
        if (div_done) begin
          f_r <= div_quot;
          p_r <= '0;
        end
      end
      S_PSCAN: begin
        if (better) begin
          best_r  <= mag[TGT_W-1:0];
          bm_r    <= m_r;
          bn_r    <= n_r;
          bp_r    <= p_r;
          found_r <= 1'b1;
        end
        p_r <= p_r + 1'b1;
        if (p_last) begin
          if (n_last) begin
            n_r <= N_BITS'(1);
            m_r <= m_r + 1'b1;
          end else begin
            n_r <= n_r + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          om_r     <= bm_r;
          on_r     <= bn_r;
          op_r     <= bp_r;
          oerr_r   <= best_r;
          ofound_r <= found_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_best_m     = om_r;
  assign out_best_n     = on_r;
  assign out_best_p     = op_r;
  assign out_best_error = oerr_r;
  assign out_found      = ofound_r;

  a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PSCAN |-> (P_BITS+1)'(p_r) < plim_r)
    else $error("p index beyond limit");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PSCAN |-> best_r <= tgt_r)
    else $error("best error above target");

  a_no_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PSCAN && !found_r) |-> (bm_r == '0 && bn_r == '0 && bp_r == '0))
    else $error("setting kept without a find");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside wait");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> out_valid_r && state_r == S_IDLE)
    else $error("result word not posted");

endmodule

// ===== src/pll_divider_search_top.sv =====
// pll divider search top level
// depends on pds_pkg, pds_regs, pds_div, pds_ctrl
//
// channel  | ports                               | direction
// in       | in_valid/in_ready, in_target_freq   | word in, one target per word
// out      | out_valid/out_ready, out_best_*     | word out, one result per word
// cfg      | psel/penable/pwrite/paddr/pwdata    | apb register access
//
// the shared divider runs once per m/n pair on a PW-bit dividend, PW = 27+N_BITS+1
// (36 at defaults), so the search time per word is set mostly by the shared divider
// in_ready is high only while the sequencer is idle
// the result register lets a new word in while the last result waits
// rst_n is synchronous; limits and reference are sampled when a word is taken
module pll_divider_search_top #(
  parameter int M_BITS = pds_pkg::M_BITS_DEF,
  parameter int N_BITS = pds_pkg::N_BITS_DEF,
  parameter int P_BITS = pds_pkg::P_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pds_pkg::ADDR_W-1:0] paddr,
  input  logic [pds_pkg::DATA_W-1:0] pwdata,
  output logic [pds_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pds_pkg::TGT_W-1:0]  in_target_freq,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [M_BITS-1:0]         out_best_m,
  output logic [N_BITS-1:0]         out_best_n,
  output logic [P_BITS-1:0]         out_best_p,
  output logic [pds_pkg::TGT_W-1:0]  out_best_error,
  output logic                      out_found
);
  import pds_pkg::*;

  localparam int PW = REF_W + N_BITS + 1;
  localparam int DV = M_BITS + 1;

  cfg_t          cfg;
  logic          div_start;
  logic [PW-1:0] div_dividend;
  logic [DV-1:0] div_divisor;
  logic          div_done;
  logic [PW-1:0] div_quot;

  pds_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pds_div #(
    .PW (PW),
    .DV (DV)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  pds_ctrl #(
    .M_BITS (M_BITS),
    .N_BITS (N_BITS),
    .P_BITS (P_BITS),
    .PW     (PW),
    .DV     (DV)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_target_freq (in_target_freq),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_m     (out_best_m),
    .out_best_n     (out_best_n),
    .out_best_p     (out_best_p),
    .out_best_error (out_best_error),
    .out_found      (out_found),
    .div_start      (div_start),
    .div_dividend   (div_dividend),
    .div_divisor    (div_divisor),
    .div_done       (div_done),
    .div_quot       (div_quot)
  );

endmodule

// ===== sim/pll_search_checker.sv =====
`timescale 1ns / 1ps
// result checker for the pll divider search: follows register writes, predicts m/n/p
// for every accepted target word and compares each result word. depends on pds_pkg
module pll_search_checker #(
  parameter int M_BITS = pds_pkg::M_BITS_DEF,
  parameter int N_BITS = pds_pkg::N_BITS_DEF,
  parameter int P_BITS = pds_pkg::P_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pds_pkg::ADDR_W-1:0] paddr,
  input  logic [pds_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [pds_pkg::TGT_W-1:0]  in_target_freq,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [M_BITS-1:0]          out_best_m,
  input  logic [N_BITS-1:0]          out_best_n,
  input  logic [P_BITS-1:0]          out_best_p,
  input  logic [pds_pkg::TGT_W-1:0]  out_best_error,
  input  logic                       out_found,
  output int                         pending,
  output int                         fails
);

  localparam int TW = pds_pkg::TGT_W;

  typedef struct packed {
    logic [M_BITS-1:0] m;
    logic [N_BITS-1:0] n;
    logic [P_BITS-1:0] p;
    logic [TW-1:0]     err;
    logic              found;
  } setting_t;

  logic [pds_pkg::REF_W-1:0] ref_q = pds_pkg::REF_RST;
  logic [pds_pkg::ML_W-1:0]  m_lim_q = pds_pkg::ML_RST;
  logic [pds_pkg::NL_W-1:0]  n_lim_q = pds_pkg::NL_RST;
  logic [pds_pkg::PL_W-1:0]  p_lim_q = pds_pkg::PL_RST;

  setting_t expected_settings[$];
  int depth = 0;
  int fail_n = 0;

  assign pending = depth;
  assign fails = fail_n;

  function automatic setting_t search_dividers(input logic [TW-1:0] target);
    setting_t s;
    longint unsigned mlim, nlim, plim, rf, tgt, best, freq, fo, diff;
    int m, n, p;
    s = '0;
    mlim = m_lim_q;
    nlim = n_lim_q;
    plim = p_lim_q;
    if (mlim > (64'd1 << M_BITS)) mlim = 64'd1 << M_BITS;
    if (nlim > (64'd1 << N_BITS)) nlim = 64'd1 << N_BITS;
    if (plim > (64'd1 << P_BITS)) plim = 64'd1 << P_BITS;
    rf = ref_q;
    tgt = target;
    best = tgt;
    for (m = 1; m < mlim; m++) begin
      for (n = 1; n < nlim; n++) begin
        freq = (rf * longint'(n + 2)) / longint'(m + 2);
        for (p = 0; p < plim; p++) begin
          fo = freq >> p;
          diff = (tgt >= fo) ? tgt - fo : fo - tgt;
          if (diff < best) begin
            best = diff;
            s.m = M_BITS'(m);
            s.n = N_BITS'(n);
            s.p = P_BITS'(p);
            s.found = 1'b1;
          end
        end
      end
    end
    s.err = TW'(best);
    return s;
  endfunction

  always @(posedge clk) begin
    setting_t want;
    if (!rst_n) begin
      ref_q = pds_pkg::REF_RST;
      m_lim_q = pds_pkg::ML_RST;
      n_lim_q = pds_pkg::NL_RST;
      p_lim_q = pds_pkg::PL_RST;
      expected_settings.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[pds_pkg::ADDR_W-1:2])
          pds_pkg::REG_REF: ref_q = pwdata[pds_pkg::REF_W-1:0];
          pds_pkg::REG_ML:  m_lim_q = pwdata[pds_pkg::ML_W-1:0];
          pds_pkg::REG_NL:  n_lim_q = pwdata[pds_pkg::NL_W-1:0];
          pds_pkg::REG_PL:  p_lim_q = pwdata[pds_pkg::PL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_settings.size() == 0) begin
          $error("result word with no target pending");
          fail_n++;
        end else begin
          want = expected_settings.pop_front();
          if (out_best_m !== want.m) begin
            $error("best_m expected %0d got %0d", want.m, out_best_m);
            fail_n++;
          end
          if (out_best_n !== want.n) begin
            $error("best_n expected %0d got %0d", want.n, out_best_n);
            fail_n++;
          end
          if (out_best_p !== want.p) begin
            $error("best_p expected %0d got %0d", want.p, out_best_p);
            fail_n++;
          end
          if (out_best_error !== want.err) begin
            $error("best_error expected %0d got %0d", want.err, out_best_error);
            fail_n++;
          end
          if (out_found !== want.found) begin
            $error("found expected %0d got %0d", want.found, out_found);
            fail_n++;
          end
        end
      end
      if (in_valid && in_ready) expected_settings.push_back(search_dividers(in_target_freq));
    end
    depth = expected_settings.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// top of the pll divider search bench: clock, reset, register writes, target words
// and receiver stalls; depends on pds_pkg, pll_divider_search_top, pll_search_checker
module tb;

  localparam int M_BITS = pds_pkg::M_BITS_DEF;
  localparam int N_BITS = pds_pkg::N_BITS_DEF;
  localparam int P_BITS = pds_pkg::P_BITS_DEF;
  localparam int TW = pds_pkg::TGT_W;
  localparam int STALL_LIMIT = 4000000;

  logic clk;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pds_pkg::ADDR_W-1:0] paddr = '0;
  logic [pds_pkg::DATA_W-1:0] pwdata = '0;
  logic [pds_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TW-1:0] in_target_freq = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [M_BITS-1:0] out_best_m;
  logic [N_BITS-1:0] out_best_n;
  logic [P_BITS-1:0] out_best_p;
  logic [TW-1:0] out_best_error;
  logic out_found;
  int pending;
  int fails;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [pds_pkg::REF_W-1:0] ref_cur = pds_pkg::REF_RST;
  logic [pds_pkg::ML_W-1:0]  m_cur = pds_pkg::ML_RST;
  logic [pds_pkg::NL_W-1:0]  n_cur = pds_pkg::NL_RST;
  logic [pds_pkg::PL_W-1:0]  p_cur = pds_pkg::PL_RST;

  pll_divider_search_top #(.M_BITS(M_BITS), .N_BITS(N_BITS), .P_BITS(P_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_target_freq(in_target_freq),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_best_m(out_best_m), .out_best_n(out_best_n), .out_best_p(out_best_p),
    .out_best_error(out_best_error), .out_found(out_found)
  );

  pll_search_checker #(.M_BITS(M_BITS), .N_BITS(N_BITS), .P_BITS(P_BITS)) chk (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_target_freq(in_target_freq),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_best_m(out_best_m), .out_best_n(out_best_n), .out_best_p(out_best_p),
    .out_best_error(out_best_error), .out_found(out_found),
    .pending(pending), .fails(fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pds_pkg::REG_REF: ref_cur = value[pds_pkg::REF_W-1:0];
      pds_pkg::REG_ML:  m_cur = value[pds_pkg::ML_W-1:0];
      pds_pkg::REG_NL:  n_cur = value[pds_pkg::NL_W-1:0];
      pds_pkg::REG_PL:  p_cur = value[pds_pkg::PL_W-1:0];
      default: ;
    endcase
  endtask

  // drop valid, then wait until every result is back and the datapath has drained
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] rf, input logic [31:0] ml,
                                input logic [31:0] nl, input logic [31:0] pl);
    wait_idle();
    cfg_write(pds_pkg::REG_REF, rf);
    cfg_write(pds_pkg::REG_ML, ml);
    cfg_write(pds_pkg::REG_NL, nl);
    cfg_write(pds_pkg::REG_PL, pl);
  endtask

  task automatic send_word(input logic [TW-1:0] tgt);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_freq <= tgt;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly targets close to a reachable candidate, the rest wide or tiny values
  function automatic logic [TW-1:0] pick_target();
    int sel, mhi, nhi, phi, m, n, p;
    longint unsigned f;
    longint t;
    sel = $urandom_range(99);
    mhi = (m_cur > 64) ? 64 : int'(m_cur);
    nhi = (n_cur > 256) ? 256 : int'(n_cur);
    phi = (p_cur > 4) ? 4 : int'(p_cur);
    if (sel < 60 && mhi >= 2 && nhi >= 2 && phi >= 1) begin
      m = $urandom_range(mhi - 1, 1);
      n = $urandom_range(nhi - 1, 1);
      p = $urandom_range(phi - 1, 0);
      f = ((longint'(ref_cur) * longint'(n + 2)) / longint'(m + 2)) >> p;
      t = longint'(f) + longint'($urandom_range(2000, 0)) - 64'sd1000;
      if (t < 0) t = 0;
      if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
      return t[TW-1:0];
    end else if (sel < 85) begin
      return TW'($urandom());
    end
    return TW'($urandom_range(1000, 0));
  endfunction

  initial begin
    int round;
    logic [31:0] rf, ml, nl, pl;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of all registers, full search space
    send_word(31'd25175000);

    apply_settings(32'd14318180, 32'd4, 32'd8, 32'd4);
    send_word(31'd0);
    send_word(31'd1);
    send_word(31'h7FFFFFFF);
    send_word(31'd14318180);
    send_word(31'd7159090);
    send_word(31'd25175000);

    // zero reference never beats the target
    apply_settings(32'd0, 32'd4, 32'd8, 32'd4);
    send_word(31'd5000000);
    send_word(31'h7FFFFFFF);

    // limits above field size saturate, largest reference
    apply_settings(32'h07FFFFFF, 32'd127, 32'd2, 32'd7);
    send_word(31'd1);
    send_word(31'd100000000);
    apply_settings(32'd100000000, 32'd2, 32'd511, 32'd1);
    send_word(31'h7FFFFFFF);
    send_word(31'd65000000);

    // empty loops
    apply_settings(32'd14318180, 32'd1, 32'd8, 32'd4);
    send_word(31'd1000000);
    apply_settings(32'd14318180, 32'd0, 32'd8, 32'd4);
    send_word(31'd1000000);
    apply_settings(32'd14318180, 32'd4, 32'd1, 32'd4);
    send_word(31'd14318180);
    apply_settings(32'd14318180, 32'd4, 32'd0, 32'd4);
    send_word(31'd14318180);
    apply_settings(32'd14318180, 32'd4, 32'd8, 32'd0);
    send_word(31'd14318180);

    // smallest nonzero reference
    apply_settings(32'd1, 32'd4, 32'd8, 32'd4);
    send_word(31'd1);
    send_word(31'd0);

    for (round = 0; round < 8; round++) begin
      wait_idle();
      case (round % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      rf = $urandom();
      if ($urandom_range(7) == 0) rf &= ~32'h07FFFFFF;
      ml = ($urandom() & ~32'h7F) |
           (($urandom_range(9) == 0) ? $urandom_range(1, 0) : $urandom_range(6, 2));
      nl = ($urandom() & ~32'h1FF) |
           (($urandom_range(9) == 0) ? $urandom_range(1, 0) : $urandom_range(10, 2));
      pl = ($urandom() & ~32'h7) |
           (($urandom_range(9) == 0) ? 32'd0 : $urandom_range(7, 1));
      apply_settings(rf, ml, nl, pl);
      repeat (10) send_word(pick_target());
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== pll_divider_search_top.f =====
src/pds_pkg.sv
src/pds_regs.sv
src/pds_div.sv
src/pds_ctrl.sv
src/pll_divider_search_top.sv
sim/pll_search_checker.sv
sim/tb.sv
